/* hw/rtl/rtpc_pkg.sv */
`default_nettype none
package rtpc_pkg;

    // fixed-point format of all signed values
    localparam int FRAC_BITS = 16;
    // gamma_factor is always Q0.16
    localparam int GF_FRAC   = 16;
    // divider numerator and quotient width: 32-bit value shifted up by FRAC_BITS
    localparam int DIV_W     = 32 + FRAC_BITS;

    // configuration register indexes
    localparam logic [2:0] CFG_THREE_DIM   = 3'd0;
    localparam logic [2:0] CFG_GAMMA       = 3'd1;
    localparam logic [2:0] CFG_VEL_SCALE   = 3'd2;
    localparam logic [2:0] CFG_PRES_SCALE  = 3'd3;
    localparam logic [2:0] CFG_TEMP_SCALE  = 3'd4;
    localparam logic [2:0] CFG_LEN_SCALE   = 3'd5;

endpackage
`default_nettype wire

/* hw/rtl/rtpc_div.sv */
`default_nettype none
// Pipelined unsigned restoring divider, one quotient bit per stage.
module rtpc_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [rtpc_pkg::DIV_W-1:0]  i_num,
    input  wire logic [31:0]                 i_den,
    output logic      [rtpc_pkg::DIV_W-1:0]  o_quo
);
    import rtpc_pkg::*;

    typedef struct packed {
        logic [31:0]      rem;
        logic [DIV_W-1:0] num;
    } t_dstep;

    // one shift-subtract step; quotient bits shift in at the bottom of num
    function automatic t_dstep f_div_step(input logic [31:0] rem,
                                          input logic [DIV_W-1:0] num,
                                          input logic [31:0] den);
        logic [32:0] t;
        logic [32:0] d;
        logic [32:0] s;
        logic        ge;
        t_dstep      r;
        t  = {rem, num[DIV_W-1]};
        d  = {1'b0, den};
        s  = t - d;
        ge = (t >= d);
        r.rem = ge ? s[31:0] : t[31:0];
        r.num = {num[DIV_W-2:0], ge};
        return r;
    endfunction

    logic [31:0]      r_rem [DIV_W-1];
    logic [31:0]      r_den [DIV_W-1];
    logic [DIV_W-1:0] r_num [DIV_W];

    for (genvar s = 0; s < DIV_W; s++) begin : g_stage
        logic [31:0]      w_rem;
        logic [DIV_W-1:0] w_num;
        logic [31:0]      w_den;
        t_dstep           w_nx;

        if (s == 0) begin : g_first
            assign w_rem = '0;
            assign w_num = i_num;
            assign w_den = i_den;
        end else begin : g_next
            assign w_rem = r_rem[s-1];
            assign w_num = r_num[s-1];
            assign w_den = r_den[s-1];
        end

        assign w_nx = f_div_step(w_rem, w_num, w_den);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[s] <= w_nx.num;
            end
        end

        // remainder and divisor are not needed past the last stage
        if (s < DIV_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= w_nx.rem;
                    r_den[s] <= w_den;
                end
            end
        end
    end

    assign o_quo = r_num[DIV_W-1];

endmodule
`default_nettype wire

/* hw/rtl/roe_to_primitive_convert_top.sv */
`default_nettype none
// Converts one mesh point's Roe parameter vector (z0..z4, Q16.16) and its
// coordinates into dimensional pressure, velocities, temperature and scaled
// coordinates. One word is taken per clock cycle while the output buffer has a
// free slot; result words carry 16 fraction bits. The 48-stage radix-2 divider
// pipeline forms the velocities and the temperature. The pipeline halts as a
// whole only when its two-word output buffer is full. A zero root density or
// any saturation sets arith_error (tuser). The scale registers are written
// through the plain write port and should only be changed while no words are
// in flight.
module roe_to_primitive_convert_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // configuration write port
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_idx,
    input  wire logic [31:0]  i_cfg_data,
    // input stream
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // roe_root_density, roe_enthalpy, roe_mom_x, roe_mom_y, roe_mom_z,
    // coord_x, coord_y, coord_z (32 bits each, from bit 0 up)
    input  wire logic [255:0] i_s_axis_tdata,
    input  wire logic         i_s_axis_tlast,   // last_point
    // output stream
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // pressure, vel_x, vel_y, vel_z, temperature, pos_x, pos_y, pos_z
    // (32 bits each, from bit 0 up)
    output logic [255:0]      o_m_axis_tdata,
    output logic              o_m_axis_tlast,   // last_out
    output logic [0:0]        o_m_axis_tuser    // arith_error
);
    import rtpc_pkg::*;

    localparam int FS = 6;   // front stages ahead of the dividers
    localparam int BS = 3;   // back stages after the dividers

    typedef struct packed {
        logic signed [31:0] z0, z1, z2, z3, z4, cx, cy, cz;
        logic signed [63:0] p00, p01, p22, p33, p44, px, py, pz;
        logic        [31:0] rho;
        logic signed [63:0] rz;
        logic        [63:0] sq;
        logic        [31:0] diff;
        logic signed [63:0] pg;
        logic        [31:0] pn, pos_x, pos_y, pos_z;
        logic               last, err, d3;
    } t_front;

    typedef struct packed {
        logic dz;
        logic nneg;
        logic npos;
        logic neg;
    } t_qfl;

    typedef struct packed {
        logic [31:0] pn, pos_x, pos_y, pos_z;
        t_qfl        fu, fv, fw, ft;
        logic        last, err, d3;
    } t_side;

    typedef struct packed {
        logic [31:0]        pn, u, v, w, t, pos_x, pos_y, pos_z;
        logic signed [63:0] pp, pu, pv, pw, pt;
        logic               last, err, d3;
    } t_back;

    typedef struct packed {
        logic         last;
        logic         err;
        logic [255:0] data;
    } t_out;

    // saturate a wide signed value to 32 bits; top bit flags saturation
    function automatic logic [32:0] f_sat(input logic signed [63:0] v);
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            return {1'b1, 32'h7FFF_FFFF};
        end else if (v < -64'sh0000_0000_8000_0000) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, v[31:0]};
    endfunction

    // signed value times unsigned scale
    function automatic logic signed [63:0] f_mul_su(input logic [31:0] a,
                                                    input logic [31:0] s);
        logic signed [32:0] sa;
        logic signed [32:0] ss;
        logic signed [65:0] p;
        sa = {a[31], a};
        ss = {1'b0, s};
        p  = sa * ss;
        return p[63:0];
    endfunction

    function automatic logic [31:0] f_abs(input logic [31:0] a);
        return a[31] ? (~a + 32'd1) : a;
    endfunction

    function automatic t_qfl f_flags(input logic [31:0] num, input logic [31:0] den);
        t_qfl f;
        f.dz   = (den == '0);
        f.nneg = num[31];
        f.npos = !num[31] && (num != '0);
        f.neg  = num[31] ^ den[31];
        return f;
    endfunction

    // apply sign, zero divisor and saturation to a quotient magnitude
    function automatic logic [32:0] f_qfin(input logic [DIV_W-1:0] q, input t_qfl f);
        logic [31:0] nq;
        nq = ~q[31:0] + 32'd1;
        if (f.dz) begin
            if (f.nneg) begin
                return {1'b1, 32'h8000_0000};
            end else if (f.npos) begin
                return {1'b1, 32'h7FFF_FFFF};
            end
            return {1'b1, 32'h0};
        end else if (f.neg) begin
            if (q > {{(DIV_W-32){1'b0}}, 32'h8000_0000}) begin
                return {1'b1, 32'h8000_0000};
            end
            return {1'b0, nq};
        end else if (q > {{(DIV_W-32){1'b0}}, 32'h7FFF_FFFF}) begin
            return {1'b1, 32'h7FFF_FFFF};
        end
        return {1'b0, q[31:0]};
    endfunction

    // configuration registers
    logic        r_three_dim;
    logic [15:0] r_gamma;
    logic [31:0] r_vel_sc, r_pres_sc, r_temp_sc, r_len_sc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_three_dim <= 1'b0;
            r_gamma     <= 16'd18725;
            r_vel_sc    <= 32'd65536;
            r_pres_sc   <= 32'd65536;
            r_temp_sc   <= 32'd65536;
            r_len_sc    <= 32'd65536;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THREE_DIM:  r_three_dim <= i_cfg_data[0];
                CFG_GAMMA:      r_gamma     <= i_cfg_data[15:0];
                CFG_VEL_SCALE:  r_vel_sc    <= i_cfg_data;
                CFG_PRES_SCALE: r_pres_sc   <= i_cfg_data;
                CFG_TEMP_SCALE: r_temp_sc   <= i_cfg_data;
                CFG_LEN_SCALE:  r_len_sc    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline enable: advance whenever the output buffer has a free slot
    logic r_qv0, r_qv1;
    logic w_en;
    assign w_en            = !(r_qv0 && r_qv1);
    assign o_s_axis_tready = w_en;

    // front stages: squares, kinetic term, pressure, scaled positions
    t_front          r_f [FS];
    t_front          n_f [FS];
    logic [FS-1:0]   r_fv;

    logic [32:0]        s_rho, s_px, s_py, s_pz, s_diff;
    logic [63:0]        w_kin;
    logic signed [63:0] w_pgs;

    always_comb begin
        // stage 0: capture word, drop z terms in 2D
        n_f[0]       = '0;
        n_f[0].d3    = r_three_dim;
        n_f[0].z0    = i_s_axis_tdata[31:0];
        n_f[0].z1    = i_s_axis_tdata[63:32];
        n_f[0].z2    = i_s_axis_tdata[95:64];
        n_f[0].z3    = i_s_axis_tdata[127:96];
        n_f[0].z4    = r_three_dim ? i_s_axis_tdata[159:128] : 32'h0;
        n_f[0].cx    = i_s_axis_tdata[191:160];
        n_f[0].cy    = i_s_axis_tdata[223:192];
        n_f[0].cz    = r_three_dim ? i_s_axis_tdata[255:224] : 32'h0;
        n_f[0].last  = i_s_axis_tlast;

        // stage 1: products
        n_f[1]     = r_f[0];
        n_f[1].p00 = r_f[0].z0 * r_f[0].z0;
        n_f[1].p01 = r_f[0].z0 * r_f[0].z1;
        n_f[1].p22 = r_f[0].z2 * r_f[0].z2;
        n_f[1].p33 = r_f[0].z3 * r_f[0].z3;
        n_f[1].p44 = r_f[0].z4 * r_f[0].z4;
        n_f[1].px  = f_mul_su(r_f[0].cx, r_len_sc);
        n_f[1].py  = f_mul_su(r_f[0].cy, r_len_sc);
        n_f[1].pz  = f_mul_su(r_f[0].cz, r_len_sc);

        // stage 2: density, rho*h, sum of squares, positions
        n_f[2]       = r_f[1];
        s_rho        = f_sat(r_f[1].p00 >>> FRAC_BITS);
        s_px         = f_sat(r_f[1].px >>> FRAC_BITS);
        s_py         = f_sat(r_f[1].py >>> FRAC_BITS);
        s_pz         = f_sat(r_f[1].pz >>> FRAC_BITS);
        n_f[2].rho   = s_rho[31:0];
        n_f[2].rz    = r_f[1].p01 >>> FRAC_BITS;
        n_f[2].sq    = r_f[1].p22 + r_f[1].p33 + r_f[1].p44;
        n_f[2].pos_x = s_px[31:0];
        n_f[2].pos_y = s_py[31:0];
        n_f[2].pos_z = s_pz[31:0];
        n_f[2].err   = s_rho[32] | s_px[32] | s_py[32] | s_pz[32];

        // stage 3: rho*h minus kinetic term
        n_f[3]      = r_f[2];
        w_kin       = r_f[2].sq >> (FRAC_BITS + 1);
        s_diff      = f_sat(r_f[2].rz - $signed(w_kin));
        n_f[3].diff = s_diff[31:0];
        n_f[3].err  = r_f[2].err | s_diff[32];

        // stage 4: times (gamma-1)/gamma
        n_f[4]    = r_f[3];
        n_f[4].pg = $signed(r_f[3].diff) * $signed({1'b0, r_gamma});

        // stage 5: nondimensional pressure
        n_f[5]    = r_f[4];
        w_pgs     = r_f[4].pg >>> GF_FRAC;
        n_f[5].pn = w_pgs[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (w_en) begin
            r_fv <= {r_fv[FS-2:0], i_s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f <= n_f;
        end
    end

    // divider inputs: magnitudes, divisor z0 or rho
    logic [31:0]      w_z0_mag;
    logic [DIV_W-1:0] w_num_u, w_num_v, w_num_w, w_num_t;
    logic [DIV_W-1:0] w_quo_u, w_quo_v, w_quo_w, w_quo_t;

    assign w_z0_mag = f_abs(r_f[FS-1].z0);
    assign w_num_u  = {f_abs(r_f[FS-1].z2), {FRAC_BITS{1'b0}}};
    assign w_num_v  = {f_abs(r_f[FS-1].z3), {FRAC_BITS{1'b0}}};
    assign w_num_w  = {f_abs(r_f[FS-1].z4), {FRAC_BITS{1'b0}}};
    assign w_num_t  = {f_abs(r_f[FS-1].pn), {FRAC_BITS{1'b0}}};

    rtpc_div u_div_u (
        .i_clk (i_clk), .i_en (w_en), .i_num (w_num_u), .i_den (w_z0_mag), .o_quo (w_quo_u)
    );
    rtpc_div u_div_v (
        .i_clk (i_clk), .i_en (w_en), .i_num (w_num_v), .i_den (w_z0_mag), .o_quo (w_quo_v)
    );
    rtpc_div u_div_w (
        .i_clk (i_clk), .i_en (w_en), .i_num (w_num_w), .i_den (w_z0_mag), .o_quo (w_quo_w)
    );
    rtpc_div u_div_t (
        .i_clk (i_clk), .i_en (w_en), .i_num (w_num_t), .i_den (r_f[FS-1].rho),
        .o_quo (w_quo_t)
    );

    // side data that runs beside the dividers
    t_side            n_side;
    t_side            r_dl [DIV_W];
    logic [DIV_W-1:0] r_dv;

    always_comb begin
        n_side.pn    = r_f[FS-1].pn;
        n_side.pos_x = r_f[FS-1].pos_x;
        n_side.pos_y = r_f[FS-1].pos_y;
        n_side.pos_z = r_f[FS-1].pos_z;
        n_side.fu    = f_flags(r_f[FS-1].z2, r_f[FS-1].z0);
        n_side.fv    = f_flags(r_f[FS-1].z3, r_f[FS-1].z0);
        n_side.fw    = f_flags(r_f[FS-1].z4, r_f[FS-1].z0);
        n_side.ft    = f_flags(r_f[FS-1].pn, r_f[FS-1].rho);
        n_side.last  = r_f[FS-1].last;
        n_side.err   = r_f[FS-1].err;
        n_side.d3    = r_f[FS-1].d3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else if (w_en) begin
            r_dv <= {r_dv[DIV_W-2:0], r_fv[FS-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dl[0] <= n_side;
            for (int k = 1; k < DIV_W; k++) begin
                r_dl[k] <= r_dl[k-1];
            end
        end
    end

    // back stages: finish quotients, scale, saturate
    t_back         r_b [BS];
    t_back         n_b [BS];
    logic [BS-1:0] r_bv;

    logic [32:0] q_u, q_v, q_w, q_t;
    logic [32:0] s_p, s_u, s_v, s_w, s_t;
    t_side       w_sd;

    always_comb begin
        w_sd = r_dl[DIV_W-1];

        // stage 0: signed quotients
        q_u          = f_qfin(w_quo_u, w_sd.fu);
        q_v          = f_qfin(w_quo_v, w_sd.fv);
        q_w          = f_qfin(w_quo_w, w_sd.fw);
        q_t          = f_qfin(w_quo_t, w_sd.ft);
        n_b[0]       = '0;
        n_b[0].pn    = w_sd.pn;
        n_b[0].u     = q_u[31:0];
        n_b[0].v     = q_v[31:0];
        n_b[0].w     = q_w[31:0];
        n_b[0].t     = q_t[31:0];
        n_b[0].pos_x = w_sd.pos_x;
        n_b[0].pos_y = w_sd.pos_y;
        n_b[0].pos_z = w_sd.pos_z;
        n_b[0].last  = w_sd.last;
        n_b[0].d3    = w_sd.d3;
        n_b[0].err   = w_sd.err | q_u[32] | q_v[32] | q_t[32] | (q_w[32] & w_sd.d3);

        // stage 1: reference scaling products
        n_b[1]    = r_b[0];
        n_b[1].pp = f_mul_su(r_b[0].pn, r_pres_sc);
        n_b[1].pu = f_mul_su(r_b[0].u, r_vel_sc);
        n_b[1].pv = f_mul_su(r_b[0].v, r_vel_sc);
        n_b[1].pw = f_mul_su(r_b[0].w, r_vel_sc);
        n_b[1].pt = f_mul_su(r_b[0].t, r_temp_sc);

        // stage 2: shift down and saturate
        s_p        = f_sat(r_b[1].pp >>> FRAC_BITS);
        s_u        = f_sat(r_b[1].pu >>> FRAC_BITS);
        s_v        = f_sat(r_b[1].pv >>> FRAC_BITS);
        s_w        = f_sat(r_b[1].pw >>> FRAC_BITS);
        s_t        = f_sat(r_b[1].pt >>> FRAC_BITS);
        n_b[2]     = r_b[1];
        n_b[2].pn  = s_p[31:0];
        n_b[2].u   = s_u[31:0];
        n_b[2].v   = s_v[31:0];
        n_b[2].w   = r_b[1].d3 ? s_w[31:0] : 32'h0;
        n_b[2].t   = s_t[31:0];
        n_b[2].err = r_b[1].err | s_p[32] | s_u[32] | s_v[32] | s_t[32]
                   | (s_w[32] & r_b[1].d3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
        end else if (w_en) begin
            r_bv <= {r_bv[BS-2:0], r_dv[DIV_W-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b <= n_b;
        end
    end

    // two-word output buffer
    t_out w_push_word;
    t_out r_q0, r_q1, n_q0, n_q1;
    logic n_qv0, n_qv1;
    logic w_push, w_pop;

    assign w_push_word.last = r_b[BS-1].last;
    assign w_push_word.err  = r_b[BS-1].err;
    assign w_push_word.data = {r_b[BS-1].pos_z, r_b[BS-1].pos_y, r_b[BS-1].pos_x,
                               r_b[BS-1].t, r_b[BS-1].w, r_b[BS-1].v,
                               r_b[BS-1].u, r_b[BS-1].pn};
    assign w_push = w_en && r_bv[BS-1];
    assign w_pop  = r_qv0 && i_m_axis_tready;

    always_comb begin
        n_q0  = r_q0;
        n_q1  = r_q1;
        n_qv0 = r_qv0;
        n_qv1 = r_qv1;
        if (w_pop) begin
            n_q0  = r_q1;
            n_qv0 = r_qv1;
            n_qv1 = 1'b0;
        end
        if (w_push) begin
            if (!n_qv0) begin
                n_q0  = w_push_word;
                n_qv0 = 1'b1;
            end else begin
                n_q1  = w_push_word;
                n_qv1 = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qv0 <= 1'b0;
            r_qv1 <= 1'b0;
        end else begin
            r_qv0 <= n_qv0;
            r_qv1 <= n_qv1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_m_axis_tvalid   = r_qv0;
    assign o_m_axis_tdata    = r_q0.data;
    assign o_m_axis_tlast    = r_q0.last;
    assign o_m_axis_tuser[0] = r_q0.err;

endmodule
`default_nettype wire
